// ===== rtl/pic_pkg.sv =====
// Shared types and constants for the polymorphic inline cache.
package pic_pkg;

  localparam int ENTRIES_DEF = 4;
  localparam int KEY_W       = 64;
  localparam int HANDLE_W    = 64;
  localparam int COUNT_W     = 3;
  localparam int STAT_W      = 32;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  typedef struct packed {
    logic found;
    logic evicted;
    logic full;
  } tbl_status_t;

endpackage

// ===== rtl/pic_if.sv =====
// Request and response channel interfaces of the inline cache.
interface pic_in_if;
  import pic_pkg::*;
  logic                valid;
  logic                ready;
  mode_t               mode;
  logic [KEY_W-1:0]    class_key;
  logic [HANDLE_W-1:0] method_value;

  modport source (output valid, mode, class_key, method_value, input ready);
  modport sink   (input valid, mode, class_key, method_value, output ready);
endinterface

interface pic_out_if;
  import pic_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [HANDLE_W-1:0] method_out;
  logic                evicted;
  logic [COUNT_W-1:0]  entry_count;
  logic                full_res;
  logic [STAT_W-1:0]   hit_total;
  logic [STAT_W-1:0]   miss_total;

  modport source (output valid, found, method_out, evicted, entry_count, full_res,
                  hit_total, miss_total, input ready);
  modport sink   (input valid, found, method_out, evicted, entry_count, full_res,
                  hit_total, miss_total, output ready);
endinterface

// ===== rtl/pic_table.sv =====
// Key and handle table: parallel compare, update, append and oldest-first shift.
module pic_table #(
  parameter int ENTRIES = pic_pkg::ENTRIES_DEF,
  localparam int CW     = $clog2(ENTRIES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  pic_pkg::mode_t               mode,
  input  logic [pic_pkg::KEY_W-1:0]    key_in,
  input  logic [pic_pkg::HANDLE_W-1:0] value_in,
  output pic_pkg::tbl_status_t         status,
  output logic [pic_pkg::HANDLE_W-1:0] handle_out,
  output logic [CW-1:0]                occupancy_next
);
  import pic_pkg::*;

  logic [KEY_W-1:0]    key_store    [ENTRIES];
  logic [HANDLE_W-1:0] handle_store [ENTRIES];
  logic [CW-1:0]       occupancy;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  slot_free;
  logic                hit;
  logic                full;
  logic                wr_en;
  logic [HANDLE_W-1:0] handle_sel;

  always_comb begin
    handle_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = (occupancy > CW'(i)) && (key_store[i] == key_in);
      slot_free[i] = (occupancy == CW'(i));
      if (match[i]) begin
        handle_sel = handle_sel | handle_store[i];
      end
    end
  end

  assign hit   = |match;
  assign full  = (occupancy == CW'(ENTRIES));
  assign wr_en = en && (mode == MODE_UPDATE);

  always_comb begin
    occupancy_next = occupancy;
    if (wr_en && !hit && !full) begin
      occupancy_next = occupancy + CW'(1);
    end
  end

  assign status.found   = hit;
  assign status.evicted = (mode == MODE_UPDATE) && !hit && full;
  assign status.full    = (occupancy_next == CW'(ENTRIES));
  assign handle_out     = (mode == MODE_LOOKUP && hit) ? handle_sel : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (en) begin
      occupancy <= occupancy_next;
    end
  end

  // Entries carry no reset; only occupied slots are ever compared.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit) begin
          if (match[i]) begin
            handle_store[i] <= value_in;
          end
        end else if (!full) begin
          if (slot_free[i]) begin
            key_store[i]    <= key_in;
            handle_store[i] <= value_in;
          end
        end else if (i == ENTRIES - 1) begin
          key_store[i]    <= key_in;
          handle_store[i] <= value_in;
        end else begin
          // drop the oldest, shift the rest down
          key_store[i]    <= key_store[(i + 1) % ENTRIES];
          handle_store[i] <= handle_store[(i + 1) % ENTRIES];
        end
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(ENTRIES))
    else $error("occupancy beyond table size");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key matched more than one entry");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (en && status.evicted) |-> (full && !hit))
    else $error("eviction without a full table");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !hit && !full) |=> (occupancy == $past(occupancy) + CW'(1)))
    else $error("append did not grow occupancy");

endmodule

// ===== rtl/pic_stats.sv =====
// Saturating hit and miss counters for lookups.
module pic_stats (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       lookup,
  input  logic                       hit,
  output logic [pic_pkg::STAT_W-1:0] hit_total_next,
  output logic [pic_pkg::STAT_W-1:0] miss_total_next
);
  import pic_pkg::*;

  logic [STAT_W-1:0] hit_counter;
  logic [STAT_W-1:0] miss_counter;

  always_comb begin
    hit_total_next  = hit_counter;
    miss_total_next = miss_counter;
    if (lookup) begin
      if (hit) begin
        if (hit_counter != '1) begin
          hit_total_next = hit_counter + STAT_W'(1);
        end
      end else if (miss_counter != '1) begin
        miss_total_next = miss_counter + STAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (en) begin
      hit_counter  <= hit_total_next;
      miss_counter <= miss_total_next;
    end
  end

endmodule

// ===== rtl/polymorphic_inline_cache.sv =====
// Polymorphic inline cache: request register, table and counters, response register.
// Flow: a request beat lands in the request register, and its response is
// then captured in the response register, which holds it until the sink takes it.
// Throughput: one beat per cycle unless the sink stalls; compare is combinational.
// Reset clears occupancy, both counters and the valid flags; stored keys and
// handles are not reset and are read only once written.
module polymorphic_inline_cache #(
  parameter int ENTRIES = pic_pkg::ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  pic_in_if.sink          req,
  pic_out_if.source       rsp
);
  import pic_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  logic                stage_valid;
  mode_t               stage_mode;
  logic [KEY_W-1:0]    stage_key;
  logic [HANDLE_W-1:0] stage_value;

  logic                out_valid;
  logic                out_found;
  logic [HANDLE_W-1:0] out_method;
  logic                out_evicted;
  logic [COUNT_W-1:0]  out_count;
  logic                out_full;
  logic [STAT_W-1:0]   out_hits;
  logic [STAT_W-1:0]   out_misses;

  logic                advance;
  tbl_status_t         status;
  logic [HANDLE_W-1:0] handle_out;
  logic [CW-1:0]       occupancy_next;
  logic [31:0]         occ_ext;
  logic [STAT_W-1:0]   hit_total_next;
  logic [STAT_W-1:0]   miss_total_next;

  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_mode  <= req.mode;
      stage_key   <= req.class_key;
      stage_value <= req.method_value;
    end
  end

  pic_table #(.ENTRIES(ENTRIES)) u_table (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .mode           (stage_mode),
    .key_in         (stage_key),
    .value_in       (stage_value),
    .status         (status),
    .handle_out     (handle_out),
    .occupancy_next (occupancy_next)
  );

  pic_stats u_stats (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .lookup          (stage_mode == MODE_LOOKUP),
    .hit             (status.found),
    .hit_total_next  (hit_total_next),
    .miss_total_next (miss_total_next)
  );

  assign occ_ext = 32'(occupancy_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the response beat until the sink takes it
  always_ff @(posedge clk) begin
    if (advance) begin
      out_found   <= status.found;
      out_method  <= handle_out;
      out_evicted <= status.evicted;
      out_count   <= occ_ext[COUNT_W-1:0];
      out_full    <= status.full;
      out_hits    <= hit_total_next;
      out_misses  <= miss_total_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.method_out  = out_method;
  assign rsp.evicted     = out_evicted;
  assign rsp.entry_count = out_count;
  assign rsp.full_res    = out_full;
  assign rsp.hit_total   = out_hits;
  assign rsp.miss_total  = out_misses;

endmodule
